// File: hdl/tsr_pkg.sv
// Shared constants, codes and types of the tile-map scroll renderer.
`default_nettype none

package tsr_pkg;

  // Tile and sheet geometry; address math relies on these being powers of two.
  localparam int TILE_SHIFT          = 4;
  localparam int TILE_PIXELS         = 1 << TILE_SHIFT;
  localparam int SHEET_SHIFT         = 8;
  localparam int SHEET_WIDTH_PIXELS  = 1 << SHEET_SHIFT;
  localparam int TPR_SHIFT           = SHEET_SHIFT - TILE_SHIFT;
  localparam int TILES_PER_ROW       = 1 << TPR_SHIFT;
  localparam int SHEET_AW            = 16;
  localparam int SHEET_DEPTH         = 1 << SHEET_AW;
  localparam int SCREEN_WIDTH_PIXELS = 320;

  localparam int MAP_ROW_COUNT = 16;
  localparam int MAP_COL_COUNT = 32;

  localparam logic [7:0] SOLID_RESET  = 8'd46;
  localparam logic [9:0] VIEW_W_RESET = 10'd640;
  localparam logic [9:0] VIEW_H_RESET = 10'd480;

  typedef enum logic [2:0] {
    CMD_MAP_WR   = 3'd0,
    CMD_SHEET_WR = 3'd1,
    CMD_SET_CAM  = 3'd2,
    CMD_RENDER   = 3'd3,
    CMD_COLLIDE  = 3'd4
  } cmd_t;

  typedef enum logic [1:0] {
    CFG_SOLID  = 2'd0,
    CFG_VIEW_W = 2'd1,
    CFG_VIEW_H = 2'd2
  } cfg_idx_t;

  localparam logic [1:0] CAM_FULL = 2'd2;
  localparam logic [1:0] CAM_NONE = 2'd3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MAP,
    ST_PIX
  } st_t;

  typedef struct packed {
    logic               we;
    logic [1:0]         cam;
    logic signed [10:0] player_x;
  } cam_wr_t;

endpackage

`default_nettype wire

// File: hdl/tilemap_scroll_renderer_unit.sv
// Top level of the tile-map scroll renderer: command decode, map and sheet memories.
`default_nettype none

// Map writes, sheet writes and camera placement take effect when accepted. A collision
// query makes one synchronous read of the tile map. A render makes a tile map read,
// then a dependent tile sheet read, each through a registered RAM port, when a nonzero
// map tile covers the pixel; when the pixel is invalid or its tile is zero it answers
// from the map read alone. The block takes the next item once the current one has left
// the map/sheet read sequence, which waits while the result register is stalled.
// Finished results sit in an output register, so a new item is accepted while a
// result waits. Map and sheet contents are undefined until written.
module tilemap_scroll_renderer_unit import tsr_pkg::*; #(
  parameter int MAP_NROWS = MAP_ROW_COUNT,
  parameter int MAP_COLS  = MAP_COL_COUNT
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [2:0]         in_command,
  input  wire logic [3:0]         in_map_row,
  input  wire logic [4:0]         in_map_col,
  input  wire logic [7:0]         in_tile_value,
  input  wire logic [15:0]        in_sheet_addr,
  input  wire logic [31:0]        in_pixel_value,
  input  wire logic [1:0]         in_viewport,
  input  wire logic signed [10:0] in_player_x,
  input  wire logic [9:0]         in_screen_x,
  input  wire logic [9:0]         in_screen_y,
  input  wire logic signed [10:0] in_probe_x,
  input  wire logic signed [10:0] in_probe_y,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic                    out_result_kind,
  output logic [31:0]             out_pixel_out,
  output logic                    out_pixel_valid,
  output logic                    out_solid,
  input  wire logic               cfg_we,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [9:0]         cfg_data
);

  localparam int MAP_DEPTH = MAP_NROWS * MAP_COLS;
  localparam int MAP_AW    = (MAP_DEPTH > 1) ? $clog2(MAP_DEPTH) : 1;

  // configuration
  logic [7:0] solid_r;
  logic [9:0] view_w_r;
  logic [9:0] view_h_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      solid_r  <= SOLID_RESET;
      view_w_r <= VIEW_W_RESET;
      view_h_r <= VIEW_H_RESET;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_SOLID:  solid_r  <= cfg_data[7:0];
        CFG_VIEW_W: view_w_r <= cfg_data;
        CFG_VIEW_H: view_h_r <= cfg_data;
        default: ;
      endcase
    end
  end

  st_t  state_r, state_nxt;
  logic acc;
  cmd_t cmd;

  assign cmd = cmd_t'(in_command);
  assign acc = in_valid && !in_stall;

  // camera
  cam_wr_t    cam_wr;
  logic [9:0] cam_off;

  assign cam_wr.we       = acc && cmd == CMD_SET_CAM && in_viewport != CAM_NONE;
  assign cam_wr.cam      = in_viewport;
  assign cam_wr.player_x = in_player_x;

  tsr_camera #(
    .MAP_COLS (MAP_COLS)
  ) u_camera (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr        (cam_wr),
    .rd_cam    (in_viewport),
    .rd_offset (cam_off)
  );

  // render and probe address decode
  logic [10:0] mx;
  logic [10:0] r_col;
  logic [10:0] r_row;
  logic        r_ok;
  logic [10:0] c_col;
  logic [10:0] c_row;
  logic        c_ok;
  logic        w_ok;
  logic [15:0] r_lin;
  logic [15:0] c_lin;
  logic [15:0] w_lin;

  assign mx    = 11'(in_screen_x) + 11'(cam_off);
  assign r_col = mx >> TILE_SHIFT;
  assign r_row = 11'(in_screen_y) >> TILE_SHIFT;
  assign r_ok  = in_viewport != CAM_NONE && in_screen_x < view_w_r
              && in_screen_y < view_h_r
              && 12'(r_col) < 12'(MAP_COLS) && 12'(r_row) < 12'(MAP_NROWS);

  assign c_col = {1'b0, in_probe_x[9:0]} >> TILE_SHIFT;
  assign c_row = {1'b0, in_probe_y[9:0]} >> TILE_SHIFT;
  assign c_ok  = !in_probe_x[10] && !in_probe_y[10]
              && 12'(c_col) < 12'(MAP_COLS) && 12'(c_row) < 12'(MAP_NROWS);

  assign w_ok  = 12'(in_map_row) < 12'(MAP_NROWS) && 12'(in_map_col) < 12'(MAP_COLS);

  assign r_lin = r_ok ? 16'(r_row) * 16'(MAP_COLS) + 16'(r_col) : '0;
  assign c_lin = c_ok ? 16'(c_row) * 16'(MAP_COLS) + 16'(c_col) : '0;
  assign w_lin = 16'(in_map_row) * 16'(MAP_COLS) + 16'(in_map_col);

  // item context held while the memories answer
  logic                  is_render_r;
  logic                  ok_r;
  logic [TILE_SHIFT-1:0] mx_lo_r;
  logic [TILE_SHIFT-1:0] my_lo_r;

  always_ff @(posedge clk) begin
    if (acc) begin
      is_render_r <= cmd == CMD_RENDER;
      ok_r        <= (cmd == CMD_RENDER) ? r_ok : c_ok;
      mx_lo_r     <= mx[TILE_SHIFT-1:0];
      my_lo_r     <= in_screen_y[TILE_SHIFT-1:0];
    end
  end

  // tile map memory
  logic [7:0]        map_mem [MAP_DEPTH];
  logic [7:0]        map_rd_r;
  logic              map_we;
  logic              map_re;
  logic [MAP_AW-1:0] map_raddr;

  assign map_we    = acc && cmd == CMD_MAP_WR && w_ok;
  assign map_raddr = (cmd == CMD_RENDER) ? r_lin[MAP_AW-1:0] : c_lin[MAP_AW-1:0];

  always_ff @(posedge clk) begin
    if (map_we) begin
      map_mem[w_lin[MAP_AW-1:0]] <= in_tile_value;
    end
    if (map_re) begin
      map_rd_r <= map_mem[map_raddr];
    end
  end

  // tile sheet memory
  logic [31:0]         sheet_mem [SHEET_DEPTH];
  logic [31:0]         sheet_rd_r;
  logic                sheet_we;
  logic                sheet_re;
  logic [7:0]          tile_id;
  logic [31:0]         sheet_x;
  logic [31:0]         sheet_y;
  logic [31:0]         sheet_lin;

  assign sheet_we  = acc && cmd == CMD_SHEET_WR;
  assign tile_id   = map_rd_r - 8'd1;
  assign sheet_x   = (32'(tile_id & 8'(TILES_PER_ROW - 1)) << TILE_SHIFT) | 32'(mx_lo_r);
  assign sheet_y   = (32'(tile_id >> TPR_SHIFT) << TILE_SHIFT) | 32'(my_lo_r);
  assign sheet_lin = sheet_x + (sheet_y << SHEET_SHIFT);

  always_ff @(posedge clk) begin
    if (sheet_we) begin
      sheet_mem[in_sheet_addr] <= in_pixel_value;
    end
    if (sheet_re) begin
      sheet_rd_r <= sheet_mem[sheet_lin[SHEET_AW-1:0]];
    end
  end

  // sequencer
  logic        out_free;
  logic        tile_hit;
  logic        out_load;
  logic        res_kind;
  logic [31:0] res_pix;
  logic        res_pix_valid;
  logic        res_solid;

  logic        out_valid_r;
  logic        out_kind_r;
  logic [31:0] out_pix_r;
  logic        out_pix_valid_r;
  logic        out_solid_r;

  assign out_free = !out_valid_r || !out_stall;
  assign tile_hit = ok_r && map_rd_r != 8'd0;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (acc && (cmd == CMD_RENDER || cmd == CMD_COLLIDE)) begin
          state_nxt = ST_MAP;
        end
      end
      ST_MAP: begin
        if (is_render_r && tile_hit) begin
          state_nxt = ST_PIX;
        end else if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_PIX: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall      = 1'b1;
    map_re        = 1'b0;
    sheet_re      = 1'b0;
    out_load      = 1'b0;
    res_kind      = 1'b0;
    res_pix       = '0;
    res_pix_valid = 1'b0;
    res_solid     = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        map_re   = in_valid && (cmd == CMD_RENDER || cmd == CMD_COLLIDE);
      end
      ST_MAP: begin
        if (is_render_r && tile_hit) begin
          sheet_re = 1'b1;
        end else begin
          // invalid or empty-tile pixel, or collision answer straight from the map read
          out_load  = out_free;
          res_kind  = !is_render_r;
          res_solid = !is_render_r && ok_r && map_rd_r == solid_r;
        end
      end
      ST_PIX: begin
        out_load      = out_free;
        res_pix       = sheet_rd_r;
        res_pix_valid = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_kind_r      <= res_kind;
      out_pix_r       <= res_pix;
      out_pix_valid_r <= res_pix_valid;
      out_solid_r     <= res_solid;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_result_kind = out_kind_r;
  assign out_pixel_out   = out_pix_r;
  assign out_pixel_valid = out_pix_valid_r;
  assign out_solid       = out_solid_r;

  a_invalid_pixel_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_pix_valid_r |-> out_pix_r == 32'd0)
    else $error("invalid pixel result carries a nonzero color word");

  a_collide_no_pixel: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_kind_r |-> !out_pix_valid_r)
    else $error("collision result flagged as a valid pixel");

  a_render_no_solid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_kind_r |-> !out_solid_r)
    else $error("render result flagged as solid");

  a_lookup_starts: assert property (@(posedge clk) disable iff (!rst_n)
    acc && (cmd == CMD_RENDER || cmd == CMD_COLLIDE) |=> state_r == ST_MAP)
    else $error("lookup item did not start a map read");

  a_pix_after_map: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_PIX |-> $past(state_r) == ST_MAP || $past(state_r) == ST_PIX)
    else $error("sheet result state entered without a map read");

endmodule

`default_nettype wire

// File: hdl/tsr_camera.sv
// Camera offset registers with player-centered placement and clamping.
`default_nettype none

module tsr_camera import tsr_pkg::*; #(
  parameter int MAP_COLS = MAP_COL_COUNT
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire cam_wr_t    wr,
  input  wire logic [1:0] rd_cam,
  output logic [9:0]      rd_offset
);

  localparam logic signed [12:0] CENTER_FULL  = 13'(SCREEN_WIDTH_PIXELS / 2);
  localparam logic signed [12:0] CENTER_SPLIT = 13'(SCREEN_WIDTH_PIXELS / 4);
  localparam logic signed [12:0] MAX_FULL  =
    13'(MAP_COLS * TILE_PIXELS - SCREEN_WIDTH_PIXELS);
  localparam logic signed [12:0] MAX_SPLIT =
    13'(MAP_COLS * TILE_PIXELS - SCREEN_WIDTH_PIXELS / 2);

  logic [9:0]         offs_r [3];
  logic signed [12:0] off;
  logic [9:0]         off_clamped;

  always_comb begin
    off = 13'(wr.player_x) - ((wr.cam == CAM_FULL) ? CENTER_FULL : CENTER_SPLIT);
    if (off > ((wr.cam == CAM_FULL) ? MAX_FULL : MAX_SPLIT)) begin
      off = (wr.cam == CAM_FULL) ? MAX_FULL : MAX_SPLIT;
    end
    if (off < 13'sd0) begin
      off = 13'sd0;
    end
    if (off > 13'sd1023) begin
      off = 13'sd1023;
    end
    off_clamped = off[9:0];
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      if (!rst_n) begin
        offs_r[i] <= '0;
      end else if (wr.we && wr.cam == 2'(i)) begin
        offs_r[i] <= off_clamped;
      end
    end
  end

  always_comb begin
    case (rd_cam)
      2'd0:    rd_offset = offs_r[0];
      2'd1:    rd_offset = offs_r[1];
      2'd2:    rd_offset = offs_r[2];
      default: rd_offset = '0;
    endcase
  end

endmodule

`default_nettype wire
